// ----- rtl/core/mbtl_pkg.sv -----
// shared types and constants of the band tile layout converter
package mbtl_pkg;

    localparam int DEF_BAND_CAPACITY = 4096;
    localparam int DEF_ELEMENT_BITS  = 64;

    localparam int DATA_W = 64;   // element field width on the stream
    localparam int CFG_W  = 13;   // register field width
    localparam int PROD_W = 2 * CFG_W;

    // configuration register indexes
    localparam logic [1:0] CFG_DIRECTION = 2'd0;
    localparam logic [1:0] CFG_BAND_ROWS = 2'd1;
    localparam logic [1:0] CFG_TILE_COLS = 2'd2;
    localparam logic [1:0] CFG_ROW_LEN   = 2'd3;

    // item kinds
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // directions
    localparam logic DIR_TO_TILED = 1'b0;
    localparam logic DIR_TO_ROWS  = 1'b1;

    // effective geometry, zero registers already replaced by one
    typedef struct packed {
        logic              dir;
        logic [CFG_W-1:0]  rows;
        logic [CFG_W-1:0]  tcols;
        logic [CFG_W-1:0]  rlen;
        logic [PROD_W-1:0] tile_span;   // rows * tcols
        logic [PROD_W-1:0] band_elems;  // rows * rlen
    } t_geom;

    // handshake state between the output stage and the top level
    typedef struct packed {
        logic can_take;   // an item accepted now finds room behind the memory
    } t_out_status;

    function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
        return (v == '0) ? CFG_W'(1) : v;
    endfunction

endpackage

// ----- rtl/core/mbtl_band_mem.sv -----
// ping-pong band buffer: one write port, one registered read port
module mbtl_band_mem #(
    parameter int ADDR_W = 12,
    parameter int ELEM_W = 64
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W:0]   i_wr_addr,
    input  logic [ELEM_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W:0]   i_rd_addr,
    output logic [ELEM_W-1:0] o_rd_data
);
    localparam int DEPTH = 2 ** (ADDR_W + 1);

    logic [ELEM_W-1:0] r_mem [DEPTH];
    logic [ELEM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/mbtl_addr_gen.sv -----
// drain address counters of the held band
module mbtl_addr_gen #(
    parameter int ADDR_W = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mbtl_pkg::t_geom      i_geom,
    input  logic [ADDR_W:0]      i_band_size,
    input  logic                 i_step,      // one element drained
    input  logic                 i_restart,   // a new band is held
    output logic [ADDR_W-1:0]    o_addr,
    output logic                 o_last
);
    import mbtl_pkg::*;

    localparam int SIZE_W = ADDR_W + 1;
    // common width for comparing counters with register values
    localparam int CMP_W  = ((ADDR_W > CFG_W) ? ADDR_W : CFG_W) + 1;
    localparam int TT_W   = ADDR_W + CFG_W;

    // counters never pass the drain count, which stays below the band size
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_col, n_col;
    logic [ADDR_W-1:0] r_row, n_row;
    logic [ADDR_W-1:0] r_tile, n_tile;

    logic              last;
    logic              col_more;
    logic              row_more;    // direction 0: another row in this tile
    logic              tile_more;   // direction 1: another tile in this row
    logic [TT_W-1:0]   tile_off;    // tile * tcols, full width
    logic [ADDR_W-1:0] rlen_a;
    logic [ADDR_W-1:0] tcols_a;
    logic [ADDR_W-1:0] span_a;
    logic [ADDR_W-1:0] row_term;
    logic [ADDR_W-1:0] tile_term;

    assign last     = ({1'b0, r_cnt} + SIZE_W'(1)) >= i_band_size;
    assign col_more = (CMP_W'(r_col) + CMP_W'(1)) < CMP_W'(i_geom.tcols);
    assign row_more = (CMP_W'(r_row) + CMP_W'(1)) < CMP_W'(i_geom.rows);

    assign tile_off  = TT_W'(r_tile) * TT_W'(i_geom.tcols);
    // (tile + 2) * tcols <= rlen, same as tile + 1 < max(1, rlen / tcols)
    assign tile_more = ((TT_W + 2)'(tile_off) + (TT_W + 2)'(i_geom.tcols)
                        + (TT_W + 2)'(i_geom.tcols)) <= (TT_W + 2)'(i_geom.rlen);

    // addresses wrap modulo the bank size, so operands are cut to ADDR_W
    assign rlen_a  = ADDR_W'(i_geom.rlen);
    assign tcols_a = ADDR_W'(i_geom.tcols);
    assign span_a  = ADDR_W'(i_geom.tile_span);

    always_comb begin
        if (i_geom.dir == DIR_TO_TILED) begin
            row_term  = r_row * rlen_a;
            tile_term = ADDR_W'(tile_off);
        end else begin
            row_term  = r_row * tcols_a;
            tile_term = r_tile * span_a;
        end
    end

    assign o_addr = tile_term + row_term + r_col;

    always_comb begin
        n_cnt  = r_cnt;
        n_col  = r_col;
        n_row  = r_row;
        n_tile = r_tile;
        if (i_restart || (i_step && last)) begin
            n_cnt  = '0;
            n_col  = '0;
            n_row  = '0;
            n_tile = '0;
        end else if (i_step) begin
            n_cnt = r_cnt + ADDR_W'(1);
            if (col_more) begin
                n_col = r_col + ADDR_W'(1);
            end else begin
                n_col = '0;
                if (i_geom.dir == DIR_TO_TILED) begin
                    if (row_more) begin
                        n_row = r_row + ADDR_W'(1);
                    end else begin
                        n_row  = '0;
                        n_tile = r_tile + ADDR_W'(1);
                    end
                end else begin
                    if (tile_more) begin
                        n_tile = r_tile + ADDR_W'(1);
                    end else begin
                        n_tile = '0;
                        n_row  = r_row + ADDR_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_tile <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_col  <= n_col;
            r_row  <= n_row;
            r_tile <= n_tile;
        end
    end

    assign o_last = last;

endmodule

// ----- rtl/core/mbtl_out_stage.sv -----
// read stage tracking and output register with backpressure
module mbtl_out_stage #(
    parameter int ELEM_W = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,      // read issued this edge
    input  logic                            i_push_last,
    input  logic [ELEM_W-1:0]               i_rd_data,
    output mbtl_pkg::t_out_status           o_status,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mbtl_pkg::DATA_W-1:0]     m_axis_tdata,  // [63:0] element_out
    output logic                            m_axis_tlast   // band_last
);
    import mbtl_pkg::*;

    logic              r_s1_vld;
    logic              r_s1_last;
    logic              r_out_vld;
    logic              r_out_last;
    logic [ELEM_W-1:0] r_out_data;
    logic              s1_move;

    assign s1_move = r_s1_vld && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_push) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s1_last <= i_push_last;
        end
        if (s1_move) begin
            r_out_data <= i_rd_data;
            r_out_last <= r_s1_last;
        end
    end

    assign o_status.can_take = !r_s1_vld || s1_move;
    assign m_axis_tvalid     = r_out_vld;
    assign m_axis_tdata      = DATA_W'(r_out_data);
    assign m_axis_tlast      = r_out_last;

endmodule

// ----- rtl/core/matrix_band_tile_layout_converter.sv -----
// top level of the band tile layout converter
//
// Matrix elements arrive one band of band_rows full rows at a time and leave
// in the other layout: direction 0 turns row-major bands into tiles of
// band_rows x tile_cols placed one after another, direction 1 turns such
// tiles back into rows. Two banks of one memory form a ping-pong pair: the
// filling bank takes one element per data transfer while the same transfer
// reads the next element of the held bank, so the block takes one input
// transfer per clock cycle, sustained while the output side keeps up and no
// configuration write is settling. The memory read happens at the input
// transfer itself; the element passes from the memory read register into
// the output register when that is free, and leaves from there. Only items
// that find a held band make a result. When the output is stalled and both
// the read stage and the output register are full, the input waits. A flush
// transfer (tuser = 1) drains one element of the held band without storing
// anything. Drain addresses are formed every cycle from the row, tile and
// column counters with small multipliers modulo the bank size, so a register
// change applies from the next element on; band size and tile span are
// products of the registers, registered after a configuration transfer,
// and the input stalls while they settle. BAND_CAPACITY must be a power of
// two; source addresses wrap modulo it. The memory has no clearing pass;
// reading an entry never written gives undefined data.
module matrix_band_tile_layout_converter #(
    parameter int BAND_CAPACITY = mbtl_pkg::DEF_BAND_CAPACITY,
    parameter int ELEMENT_BITS  = mbtl_pkg::DEF_ELEMENT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mbtl_pkg::DATA_W-1:0]   s_axis_tdata,   // [63:0] element_in
    input  logic                          s_axis_tuser,   // [0] op
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mbtl_pkg::DATA_W-1:0]   m_axis_tdata,   // [63:0] element_out
    output logic                          m_axis_tlast,   // band_last
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [mbtl_pkg::CFG_W-1:0]    i_cfg_data
);
    import mbtl_pkg::*;

    localparam int ADDR_W = $clog2(BAND_CAPACITY);
    localparam int SIZE_W = ADDR_W + 1;

    // raw registers as written
    logic             r_dir;
    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_tcols;
    logic [CFG_W-1:0] r_rlen;
    // derived geometry, registered from the raw registers
    t_geom            r_geom;
    t_geom            n_geom;
    logic             r_settle;   // derived geometry not yet current

    logic              r_fill_bank;
    logic [ADDR_W-1:0] r_fill_cnt;
    logic              r_held;

    logic              cfg_xfer;
    logic              in_xfer;
    logic              is_flush;
    logic              wr_en;
    logic              drain;
    logic              band_done;
    logic [SIZE_W-1:0] band_size;
    logic [ADDR_W-1:0] drain_addr;
    logic              drain_last;
    logic [ELEMENT_BITS-1:0] rd_data;
    t_out_status       out_status;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_TO_TILED;
            r_rows  <= CFG_W'(1);
            r_tcols <= CFG_W'(1);
            r_rlen  <= CFG_W'(1);
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                CFG_DIRECTION: r_dir   <= i_cfg_data[0];
                CFG_BAND_ROWS: r_rows  <= i_cfg_data;
                CFG_TILE_COLS: r_tcols <= i_cfg_data;
                CFG_ROW_LEN:   r_rlen  <= i_cfg_data;
                default:       r_dir   <= r_dir;
            endcase
        end
    end

    // zero registers act as one
    always_comb begin
        n_geom.dir        = r_dir;
        n_geom.rows       = at_least_one(r_rows);
        n_geom.tcols      = at_least_one(r_tcols);
        n_geom.rlen       = at_least_one(r_rlen);
        n_geom.tile_span  = PROD_W'(n_geom.rows) * PROD_W'(n_geom.tcols);
        n_geom.band_elems = PROD_W'(n_geom.rows) * PROD_W'(n_geom.rlen);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.dir        <= DIR_TO_TILED;
            r_geom.rows       <= CFG_W'(1);
            r_geom.tcols      <= CFG_W'(1);
            r_geom.rlen       <= CFG_W'(1);
            r_geom.tile_span  <= PROD_W'(1);
            r_geom.band_elems <= PROD_W'(1);
            r_settle          <= 1'b0;
        end else begin
            r_geom   <= n_geom;
            r_settle <= cfg_xfer;
        end
    end

    // band size saturates at the bank capacity
    assign band_size = (r_geom.band_elems > PROD_W'(BAND_CAPACITY))
                       ? SIZE_W'(BAND_CAPACITY) : SIZE_W'(r_geom.band_elems);

    assign s_axis_tready = !r_settle && out_status.can_take;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign is_flush      = (s_axis_tuser == OP_FLUSH);
    assign wr_en         = in_xfer && !is_flush;
    assign drain         = in_xfer && r_held;
    assign band_done     = wr_en && (({1'b0, r_fill_cnt} + SIZE_W'(1)) >= band_size);

    // fill side and bank swap; a swap in the same transfer as the final
    // drain of the old band leaves the new band held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_bank <= 1'b0;
            r_fill_cnt  <= '0;
            r_held      <= 1'b0;
        end else begin
            if (band_done) begin
                r_fill_cnt  <= '0;
                r_fill_bank <= ~r_fill_bank;
            end else if (wr_en) begin
                r_fill_cnt <= r_fill_cnt + ADDR_W'(1);
            end
            if (band_done) begin
                r_held <= 1'b1;
            end else if (drain && drain_last) begin
                r_held <= 1'b0;
            end
        end
    end

    mbtl_addr_gen #(
        .ADDR_W(ADDR_W)
    ) u_addr_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (r_geom),
        .i_band_size(band_size),
        .i_step     (drain),
        .i_restart  (band_done),
        .o_addr     (drain_addr),
        .o_last     (drain_last)
    );

    // write and read always hit opposite banks
    mbtl_band_mem #(
        .ADDR_W(ADDR_W),
        .ELEM_W(ELEMENT_BITS)
    ) u_band_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr({r_fill_bank, r_fill_cnt}),
        .i_wr_data(s_axis_tdata[ELEMENT_BITS-1:0]),
        .i_rd_en  (drain),
        .i_rd_addr({~r_fill_bank, drain_addr}),
        .o_rd_data(rd_data)
    );

    mbtl_out_stage #(
        .ELEM_W(ELEMENT_BITS)
    ) u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (drain),
        .i_push_last  (drain_last),
        .i_rd_data    (rd_data),
        .o_status     (out_status),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule
